// ----- rtl/core/dltq_pkg.sv -----
// types and codes shared by the delta-list timer queue
`default_nettype none

package dltq_pkg;

   // command codes of a request
   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;

   // status codes of a response
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_INACTIVE = 1'b1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [3:0]  timer_slot;
      logic [23:0] period_ms;
      logic        reload_enable;
      logic [23:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic        expired_valid;
      logic [3:0]  expired_slot;
      logic        last;
      logic [23:0] head_remaining;
      logic        status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UNLINK,
      ST_LINK,
      ST_TICK,
      ST_RELOAD,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/core/delta_list_timer_queue.sv -----
// delta-list timer queue: sorted timer list walked by a small sequencer
// sequence: add/remove walk the list one entry a cycle, an add unlinking an active slot before linking it;
// a tick accepts the request, expires entries from the head, scans the expired entries for reload
// plus a list walk per reloaded entry, then one response per expired entry (one if none expired)
// throughput: one request at a time, req_ready is high only in idle
// reset: synchronous, empties the list and clears all active flags
`default_nettype none

module delta_list_timer_queue
   import dltq_pkg::*;
#(
   parameter int NUM_TIMERS = 16,
   parameter int TIME_BITS  = 24
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int SLOT_LIMIT = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;
   localparam int SW = $clog2(SLOT_LIMIT);
   localparam int CW = $clog2(SLOT_LIMIT + 1);
   localparam logic [TIME_BITS-1:0] TMAX = '1;

   state_type state_ff, state_in;

   logic [1:0]           cmd_ff, cmd_in;
   logic [SW-1:0]        slot_ff, slot_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [TIME_BITS-1:0] el_ff, el_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        ndone_ff, ndone_in;
   logic [CW-1:0]        ridx_ff, ridx_in;
   logic [CW-1:0]        eidx_ff, eidx_in;
   logic                 status_ff, status_in;

   logic [SW-1:0]        order_ff [SLOT_LIMIT];
   logic [SW-1:0]        order_in [SLOT_LIMIT];
   logic [SW-1:0]        done_ff  [SLOT_LIMIT];
   logic [SW-1:0]        done_in  [SLOT_LIMIT];
   logic [TIME_BITS-1:0] delta_ff [SLOT_LIMIT];
   logic [TIME_BITS-1:0] delta_in [SLOT_LIMIT];
   logic [TIME_BITS-1:0] rper_ff  [SLOT_LIMIT];
   logic [TIME_BITS-1:0] rper_in  [SLOT_LIMIT];
   logic [SLOT_LIMIT-1:0] per_ff, per_in;
   logic [SLOT_LIMIT-1:0] act_ff, act_in;

   // request decode
   logic                 req_xfer;
   logic                 req_slot_ok;
   logic [SW-1:0]        req_slot;
   logic [TIME_BITS-1:0] req_period;
   logic [TIME_BITS-1:0] req_elapsed;

   assign req_xfer    = req_valid && req_ready;
   assign req_slot_ok = 5'(req_data.timer_slot) < 5'(SLOT_LIMIT);
   assign req_slot    = req_data.timer_slot[SW-1:0];
   assign req_period  = (32'(req_data.period_ms) > 32'(TMAX)) ? TMAX
                        : TIME_BITS'(req_data.period_ms);
   assign req_elapsed = (32'(req_data.elapsed_ms) > 32'(TMAX)) ? TMAX
                        : TIME_BITS'(req_data.elapsed_ms);

   // list walk operands
   logic                   pos_lt_cnt, pos_end, nxt_ok;
   logic [CW-1:0]          pos_p1;
   logic [SW-1:0]          cur_slot, nxt_slot, head_slot, rel_slot;
   logic [TIME_BITS-1:0]   cur_delta, nxt_delta, head_delta;
   logic [TIME_BITS:0]     merge_sum;
   logic [TIME_BITS-1:0]   merge_sat;
   logic                   found, t_gt, t_eq, head_gt, cnt_zero, r_end, r_per;
   logic                   emit_last, tick_hit;

   assign pos_p1     = pos_ff + 1'b1;
   assign pos_lt_cnt = pos_ff < cnt_ff;
   assign pos_end    = pos_ff == cnt_ff;
   assign nxt_ok     = pos_p1 < cnt_ff;
   assign cur_slot   = order_ff[pos_lt_cnt ? pos_ff[SW-1:0] : '0];
   assign nxt_slot   = order_ff[nxt_ok ? pos_p1[SW-1:0] : '0];
   assign head_slot  = order_ff[0];
   assign cur_delta  = delta_ff[cur_slot];
   assign nxt_delta  = delta_ff[nxt_slot];
   assign head_delta = delta_ff[head_slot];
   assign merge_sum  = {1'b0, nxt_delta} + {1'b0, delta_ff[slot_ff]};
   assign merge_sat  = merge_sum[TIME_BITS] ? TMAX : merge_sum[TIME_BITS-1:0];
   assign found      = cur_slot == slot_ff;
   assign t_gt       = time_ff > cur_delta;
   assign t_eq       = time_ff == cur_delta;
   assign head_gt    = head_delta > el_ff;
   assign cnt_zero   = cnt_ff == '0;
   assign r_end      = ridx_ff == ndone_ff;
   assign rel_slot   = done_ff[r_end ? '0 : ridx_ff[SW-1:0]];
   assign r_per      = per_ff[rel_slot];
   assign tick_hit   = (cmd_ff == CMD_TICK) && (ndone_ff != '0);
   assign emit_last  = !tick_hit || ((eidx_ff + 1'b1) == ndone_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               unique case (req_data.cmd)
                  CMD_ADD: begin
                     if (!req_slot_ok) state_in = ST_EMIT;
                     else if (act_ff[req_slot]) state_in = ST_UNLINK;
                     else state_in = ST_LINK;
                  end
                  CMD_REMOVE: begin
                     if (req_slot_ok && act_ff[req_slot]) state_in = ST_UNLINK;
                     else state_in = ST_EMIT;
                  end
                  CMD_TICK: state_in = ST_TICK;
                  default:  state_in = ST_EMIT;
               endcase
            end
         end
         ST_UNLINK: begin
            if (found) state_in = (cmd_ff == CMD_ADD) ? ST_LINK : ST_EMIT;
         end
         ST_LINK: begin
            if (pos_end || !t_gt) state_in = (cmd_ff == CMD_TICK) ? ST_RELOAD : ST_EMIT;
         end
         ST_TICK: begin
            if (cnt_zero || head_gt) state_in = ST_RELOAD;
         end
         ST_RELOAD: begin
            if (r_end) state_in = ST_EMIT;
            else if (r_per) state_in = ST_LINK;
         end
         ST_EMIT: begin
            if (rsp_ready && emit_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and list updates
   always_comb begin
      logic          drop_en, ins_en;
      logic [CW-1:0] drop_pos, ins_pos;
      drop_en   = 1'b0;
      ins_en    = 1'b0;
      drop_pos  = '0;
      ins_pos   = '0;
      cmd_in    = cmd_ff;
      slot_in   = slot_ff;
      time_in   = time_ff;
      el_in     = el_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      ndone_in  = ndone_ff;
      ridx_in   = ridx_ff;
      eidx_in   = eidx_ff;
      status_in = status_ff;
      order_in  = order_ff;
      done_in   = done_ff;
      delta_in  = delta_ff;
      rper_in   = rper_ff;
      per_in    = per_ff;
      act_in    = act_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cmd_in    = req_data.cmd;
               slot_in   = req_slot;
               time_in   = req_period;
               el_in     = req_elapsed;
               pos_in    = '0;
               ndone_in  = '0;
               ridx_in   = '0;
               eidx_in   = '0;
               status_in = STATUS_OK;
               if (req_data.cmd == CMD_ADD && req_slot_ok) begin
                  rper_in[req_slot] = req_period;
                  per_in[req_slot]  = req_data.reload_enable;
               end
               if (req_data.cmd == CMD_REMOVE && !(req_slot_ok && act_ff[req_slot]))
                  status_in = STATUS_INACTIVE;
            end
         end
         ST_UNLINK: begin
            // hand the delta to the follower and close the gap
            if (found) begin
               if (nxt_ok) delta_in[nxt_slot] = merge_sat;
               drop_en          = 1'b1;
               drop_pos         = pos_ff;
               cnt_in           = cnt_ff - 1'b1;
               act_in[slot_ff]  = 1'b0;
               pos_in           = '0;
            end else begin
               pos_in = pos_p1;
            end
         end
         ST_LINK: begin
            // walk until the new deadline fits
            if (pos_end) begin
               delta_in[slot_ff] = time_ff;
               ins_en = 1'b1;
               ins_pos = cnt_ff;
            end else if (t_gt) begin
               time_in = time_ff - cur_delta;
               pos_in  = pos_p1;
            end else if (t_eq) begin
               delta_in[slot_ff] = '0;
               ins_en = 1'b1;
               ins_pos = pos_p1;
            end else begin
               delta_in[cur_slot] = cur_delta - time_ff;
               delta_in[slot_ff]  = time_ff;
               ins_en = 1'b1;
               ins_pos = pos_ff;
            end
            if (ins_en) begin
               act_in[slot_ff] = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               pos_in = '0;
            end
         end
         ST_TICK: begin
            // expire from the head while the elapsed time covers it
            if (!cnt_zero) begin
               if (head_gt) begin
                  delta_in[head_slot] = head_delta - el_ff;
               end else begin
                  el_in = el_ff - head_delta;
                  delta_in[head_slot] = '0;
                  drop_en = 1'b1;
                  drop_pos = '0;
                  cnt_in = cnt_ff - 1'b1;
                  act_in[head_slot] = 1'b0;
                  done_in[ndone_ff[SW-1:0]] = head_slot;
                  ndone_in = ndone_ff + 1'b1;
               end
            end
         end
         ST_RELOAD: begin
            // re-arm periodic expired slots in expiry order
            if (!r_end) begin
               ridx_in = ridx_ff + 1'b1;
               if (r_per) begin
                  slot_in = rel_slot;
                  time_in = rper_ff[rel_slot];
                  pos_in  = '0;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_ready) eidx_in = eidx_ff + 1'b1;
         end
         default: ;
      endcase

      // list cell shifts
      for (int j = 0; j < SLOT_LIMIT; j++) begin
         if (drop_en && CW'(j) >= drop_pos && j + 1 < SLOT_LIMIT)
            order_in[j] = order_ff[(j + 1 < SLOT_LIMIT) ? j + 1 : j];
         if (ins_en) begin
            if (CW'(j) > ins_pos) order_in[j] = order_ff[(j > 0) ? j - 1 : 0];
            else if (CW'(j) == ins_pos) order_in[j] = slot_ff;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         act_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         act_ff   <= act_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      slot_ff   <= slot_in;
      time_ff   <= time_in;
      el_ff     <= el_in;
      pos_ff    <= pos_in;
      ndone_ff  <= ndone_in;
      ridx_ff   <= ridx_in;
      eidx_ff   <= eidx_in;
      status_ff <= status_in;
      order_ff  <= order_in;
      done_ff   <= done_in;
      delta_ff  <= delta_in;
      rper_ff   <= rper_in;
      per_ff    <= per_in;
   end

   // handshake outputs
   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = state_ff == ST_EMIT;

   // response payload, held steady while a response is stalled
   always_comb begin
      rsp_data.expired_valid  = tick_hit;
      rsp_data.expired_slot   = tick_hit ? 4'(done_ff[eidx_ff[SW-1:0]]) : 4'd0;
      rsp_data.last           = emit_last;
      rsp_data.head_remaining = cnt_zero ? 24'd0 : 24'(head_delta);
      rsp_data.status         = status_ff;
   end

   // entry count tracks active slots
   a_count: assert property (@(posedge clock) disable iff (reset)
      $countones(act_ff) == 32'(cnt_ff))
      else $error("entry count differs from active slots");

   // list never exceeds the slot space
   a_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(SLOT_LIMIT))
      else $error("entry count overflow");

   // no request taken while a response is pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response overlap");

   // a stalled response keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

`default_nettype wire

// ----- dv/tb_delta_list_timer_queue.sv -----
// testbench of the delta-list timer queue: directed and random commands against a predictor
`timescale 1ns / 100ps
`default_nettype none

module tb_delta_list_timer_queue;
   import dltq_pkg::*;

   localparam int SLOTS = 16;
   localparam logic [23:0] TIME_MAX = 24'hFFFFFF;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   delta_list_timer_queue dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic [3:0]  list_order [SLOTS];
   logic [23:0] slot_delta [SLOTS];
   logic [23:0] slot_period [SLOTS];
   logic        slot_reload [SLOTS];
   logic        slot_active [SLOTS];
   int          list_len = 0;

   rsp_type expected_rsps [$];
   int      errors = 0;
   int      items_sent = 0;
   int      rsps_seen = 0;
   int      expiries_seen = 0;
   bit      rsp_stall_off = 0;
   int      rsp_hold = 0;

   function automatic logic [23:0] sat_add(logic [23:0] a, logic [23:0] b);
      logic [24:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[24] ? TIME_MAX : s[23:0];
   endfunction

   function automatic logic [23:0] head_time();
      return (list_len == 0) ? 24'd0 : slot_delta[list_order[0]];
   endfunction

   function automatic void drop_at(int pos);
      for (int i = pos; i + 1 < list_len; i++) list_order[i] = list_order[i + 1];
      list_len--;
   endfunction

   function automatic void place_at(int pos, logic [3:0] slot);
      for (int i = list_len; i > pos; i--) list_order[i] = list_order[i - 1];
      list_order[pos] = slot;
      list_len++;
   endfunction

   function automatic bit unlink(logic [3:0] slot);
      if (!slot_active[slot]) return 0;
      for (int i = 0; i < list_len; i++) begin
         if (list_order[i] == slot) begin
            if (i + 1 < list_len)
               slot_delta[list_order[i + 1]] =
                  sat_add(slot_delta[list_order[i + 1]], slot_delta[slot]);
            drop_at(i);
            break;
         end
      end
      slot_active[slot] = 0;
      return 1;
   endfunction

   function automatic void link(logic [3:0] slot, logic [23:0] t);
      logic [3:0] cur;
      if (list_len >= SLOTS) return;
      for (int i = 0; i < list_len; i++) begin
         cur = list_order[i];
         if (t > slot_delta[cur]) begin
            t -= slot_delta[cur];
         end else if (t == slot_delta[cur]) begin
            slot_delta[slot] = 0;
            slot_active[slot] = 1;
            place_at(i + 1, slot);
            return;
         end else begin
            slot_delta[cur] -= t;
            slot_delta[slot] = t;
            slot_active[slot] = 1;
            place_at(i, slot);
            return;
         end
      end
      slot_delta[slot] = t;
      slot_active[slot] = 1;
      place_at(list_len, slot);
   endfunction

   // work out the responses of one request and queue them
   function automatic void predict_timer_step(req_type r);
      rsp_type    o;
      logic [3:0] fired [$];
      logic [3:0] h;
      logic [23:0] el;
      bit         found;
      o = '0;
      o.last = 1'b1;
      case (r.cmd)
         CMD_ADD: begin
            found = unlink(r.timer_slot);
            slot_period[r.timer_slot] = r.period_ms;
            slot_reload[r.timer_slot] = r.reload_enable;
            link(r.timer_slot, r.period_ms);
         end
         CMD_REMOVE: begin
            found = unlink(r.timer_slot);
            o.status = found ? STATUS_OK : STATUS_INACTIVE;
         end
         CMD_TICK: begin
            el = r.elapsed_ms;
            while (list_len > 0 && fired.size() < SLOTS) begin
               h = list_order[0];
               if (slot_delta[h] > el) begin
                  slot_delta[h] -= el;
                  break;
               end
               el -= slot_delta[h];
               slot_delta[h] = 0;
               drop_at(0);
               slot_active[h] = 0;
               fired.push_back(h);
            end
            foreach (fired[i])
               if (slot_reload[fired[i]]) link(fired[i], slot_period[fired[i]]);
         end
         default: ;
      endcase
      o.head_remaining = head_time();
      if (fired.size() == 0) begin
         expected_rsps.push_back(o);
      end else begin
         foreach (fired[i]) begin
            o.expired_valid = 1'b1;
            o.expired_slot = fired[i];
            o.last = (i == fired.size() - 1);
            expected_rsps.push_back(o);
         end
      end
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // send one request and predict its responses on transfer
   task automatic send_req(req_type r);
      int n;
      n = gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predict_timer_step(r);
      items_sent++;
   endtask

   function automatic req_type make_req(logic [1:0] cmd, logic [3:0] slot,
                                        logic [23:0] period, logic rel,
                                        logic [23:0] elapsed);
      req_type r;
      r.cmd = cmd;
      r.timer_slot = slot;
      r.period_ms = period;
      r.reload_enable = rel;
      r.elapsed_ms = elapsed;
      return r;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   // response ready with random stalls, mostly short and a few long
   always @(posedge clock) begin
      int p;
      if (reset || rsp_stall_off) begin
         rsp_ready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else begin
         p = $urandom_range(0, 99);
         if (p < 70) begin
            rsp_ready <= 1'b1;
         end else if (p < 95) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_hold = $urandom_range(10, 40);
            rsp_ready <= 1'b0;
         end
      end
   end

   // check each response transfer
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsps_seen++;
         if (rsp_data.expired_valid) expiries_seen++;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (want.expired_valid !== rsp_data.expired_valid) begin
               $display("%0t: expired_valid expected %0d actual %0d", $time,
                        want.expired_valid, rsp_data.expired_valid);
               errors++;
            end
            if (want.expired_slot !== rsp_data.expired_slot) begin
               $display("%0t: expired_slot expected %0d actual %0d", $time,
                        want.expired_slot, rsp_data.expired_slot);
               errors++;
            end
            if (want.last !== rsp_data.last) begin
               $display("%0t: last expected %0d actual %0d", $time,
                        want.last, rsp_data.last);
               errors++;
            end
            if (want.head_remaining !== rsp_data.head_remaining) begin
               $display("%0t: head_remaining expected %0d actual %0d", $time,
                        want.head_remaining, rsp_data.head_remaining);
               errors++;
            end
            if (want.status !== rsp_data.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_data.status);
               errors++;
            end
         end
      end
   end

   // extremes, every command, equal deadlines, re-add, bad remove, zero period
   task automatic test_directed();
      send_req(make_req(CMD_REMOVE, 4'd3, 24'd0, 1'b0, 24'd0));
      send_req(make_req(CMD_TICK, 4'd0, 24'd0, 1'b0, 24'd5));
      send_req(make_req(CMD_ADD, 4'd0, 24'd100, 1'b0, TIME_MAX));
      send_req(make_req(CMD_ADD, 4'd1, 24'd100, 1'b1, 24'd0));
      send_req(make_req(CMD_ADD, 4'd2, 24'd100, 1'b0, 24'd0));
      send_req(make_req(CMD_ADD, 4'd15, TIME_MAX, 1'b1, 24'd0));
      send_req(make_req(CMD_ADD, 4'd4, 24'd0, 1'b1, 24'd0));
      send_req(make_req(CMD_ADD, 4'd5, 24'd50, 1'b0, 24'd0));
      send_req(make_req(CMD_ADD, 4'd5, 24'd150, 1'b0, 24'd0));
      send_req(make_req(CMD_REMOVE, 4'd1, 24'd0, 1'b0, 24'd0));
      send_req(make_req(CMD_REMOVE, 4'd1, 24'd0, 1'b0, 24'd0));
      send_req(make_req(CMD_UNKNOWN, 4'd7, TIME_MAX, 1'b1, TIME_MAX));
      send_req(make_req(CMD_TICK, 4'd0, 24'd0, 1'b0, 24'd0));
      send_req(make_req(CMD_TICK, 4'd0, 24'd0, 1'b0, 24'd100));
      send_req(make_req(CMD_TICK, 4'd0, 24'd0, 1'b0, 24'd60));
      send_req(make_req(CMD_TICK, 4'd0, 24'd0, 1'b0, TIME_MAX));
      send_req(make_req(CMD_REMOVE, 4'd15, 24'd0, 1'b0, 24'd0));
      send_req(make_req(CMD_REMOVE, 4'd4, 24'd0, 1'b0, 24'd0));
   endtask

   // all sixteen slots expire in one tick
   task automatic test_full_list();
      for (int s = 0; s < SLOTS; s++)
         send_req(make_req(CMD_ADD, s[3:0], 24'($urandom_range(1, 20)), s[0], 24'd0));
      send_req(make_req(CMD_ADD, 4'd9, 24'd3, 1'b1, 24'd0));
      send_req(make_req(CMD_TICK, 4'd0, 24'd0, 1'b0, 24'd1000));
      // pause until everything is back
      wait_drained();
      send_req(make_req(CMD_TICK, 4'd0, 24'd0, 1'b0, TIME_MAX));
      for (int s = 0; s < SLOTS; s++)
         send_req(make_req(CMD_REMOVE, s[3:0], 24'd0, 1'b0, 24'd0));
   endtask

   // random mix, mostly small times so ticks keep expiring timers
   task automatic test_random(int count);
      req_type r;
      int p;
      for (int n = 0; n < count; n++) begin
         r.timer_slot = 4'($urandom_range(0, 15));
         r.reload_enable = 1'($urandom_range(0, 1));
         r.period_ms = ($urandom_range(0, 9) == 0) ? 24'($urandom)
                                                    : 24'($urandom_range(0, 300));
         r.elapsed_ms = ($urandom_range(0, 19) == 0) ? 24'($urandom)
                                                      : 24'($urandom_range(0, 150));
         p = $urandom_range(0, 99);
         if (p < 45) r.cmd = CMD_ADD;
         else if (p < 65) r.cmd = CMD_REMOVE;
         else if (p < 97) r.cmd = CMD_TICK;
         else r.cmd = CMD_UNKNOWN;
         if (n == count / 2) rsp_stall_off = 1;
         if (n == count * 3 / 4) rsp_stall_off = 0;
         send_req(r);
      end
   endtask

   initial begin
      for (int s = 0; s < SLOTS; s++) slot_active[s] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_list();
      test_random(150);
      wait_drained();
      repeat (100) @(posedge clock);
      $display("Sent %0d requests, checked %0d responses with %0d expiries.",
               items_sent, rsps_seen, expiries_seen);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire
